[rtl/hrv_stress_classifier_assert.svh]
// Assertion macros for the HRV stress classifier
`ifndef HRV_STRESS_CLASSIFIER_ASSERT_SVH
`define HRV_STRESS_CLASSIFIER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define HRV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define HRV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/hrv_pkg.sv]
// Shared types and constants for the HRV stress classifier
package hrv_pkg;
  typedef struct packed {
    logic [11:0] interval_ms;
    logic        last_sample;
  } hrv_in_t;

  typedef struct packed {
    logic [15:0] sdnn_q4;
    logic [15:0] rmssd_q4;
    logic [10:0] pnn50_q4;
    logic [1:0]  stress_points;
    logic [1:0]  stress_colour;
    logic [1:0]  window_status;
  } hrv_out_t;

  localparam logic [1:0] CfgSdnn  = 2'd0;
  localparam logic [1:0] CfgRmssd = 2'd1;
  localparam logic [1:0] CfgPnn   = 2'd2;
  localparam logic [1:0] CfgDiff  = 2'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusShort = 2'd1;
  localparam logic [1:0] StatusOver  = 2'd2;

  // divider operand selects
  localparam logic [1:0] DivSelVar  = 2'd0;
  localparam logic [1:0] DivSelDiff = 2'd1;
  localparam logic [1:0] DivSelPnn  = 2'd2;

  // finishing operations the controller issues to the datapath
  typedef struct packed {
    logic accum;      // fold input sample into window sums
    logic fin_start;  // latch window, prepare division operands
    logic div_start;  // start one division
    logic [1:0] div_sel;  // 0 var, 1 diff, 2 pnn
    logic sqrt_start;
    logic sqrt_sel;   // 0 sdnn, 1 rmssd
    logic emit;       // build the result and clear the window
  } hrv_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic need_fin;   // window has at least two samples
  } hrv_sts_t;
endpackage

[rtl/hrv_stress_classifier.sv]
// HRV stress classifier: config registers, controller and datapath
// Takes one beat interval per cycle while collecting a window. After the sample
// marked last, a window of two or more samples is finished with a shared
// one-bit-per-cycle divider (three divisions) and a two-bit-per-cycle
// square-root unit (two roots); input is held off meanwhile. A finished
// result waits in the output register until taken, and the next window does
// not start its finishing steps before then.
module hrv_stress_classifier #(
  parameter int unsigned MAX_SAMPLES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hrv_pkg::hrv_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hrv_pkg::hrv_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [11:0]       cfg_data_i
);
  import hrv_pkg::*;

  logic [11:0] sdnn_lim_q, rmssd_lim_q, diff_lim_q;
  logic [6:0]  pnn_lim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdnn_lim_q  <= 12'd50;
      rmssd_lim_q <= 12'd42;
      pnn_lim_q   <= 7'd3;
      diff_lim_q  <= 12'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSdnn:  sdnn_lim_q  <= cfg_data_i;
        CfgRmssd: rmssd_lim_q <= cfg_data_i;
        CfgPnn:   pnn_lim_q   <= cfg_data_i[6:0];
        CfgDiff:  diff_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hrv_cmd_t cmd;
  hrv_sts_t sts;
  hrv_out_t res;
  logic     load;

  hrv_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .last_i(in_data_i.last_sample),
    .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts), .load_o(load)
  );

  hrv_datapath #(.MaxSamples(MAX_SAMPLES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_i(in_data_i),
    .sdnn_limit_i(sdnn_lim_q), .rmssd_limit_i(rmssd_lim_q),
    .pnn50_limit_i(pnn_lim_q), .nn_diff_limit_i(diff_lim_q),
    .res_o(res)
  );

  always_ff @(posedge clk_i) begin
    if (load) out_data_o <= res;
  end
endmodule

[rtl/hrv_datapath.sv]
// Datapath: window accumulators, shared divider and square-root unit
module hrv_datapath #(
  parameter int unsigned MaxSamples = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hrv_pkg::hrv_cmd_t cmd_i,
  output hrv_pkg::hrv_sts_t sts_o,
  input  hrv_pkg::hrv_in_t  in_i,
  input  logic [11:0]       sdnn_limit_i,
  input  logic [11:0]       rmssd_limit_i,
  input  logic [6:0]        pnn50_limit_i,
  input  logic [11:0]       nn_diff_limit_i,
  output hrv_pkg::hrv_out_t res_o
);
  import hrv_pkg::*;

  localparam int unsigned CntW = $clog2(MaxSamples + 1);
  localparam int unsigned SumW = CntW + 12;
  localparam int unsigned SqW  = CntW + 24;
  // n*Q - S*S fits in 2*SqW; times 256
  localparam int unsigned NumW = 2 * SqW + 8;
  localparam int unsigned DenW = 2 * CntW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0]  sq_q, sq_d, dsq_q, dsq_d;
  logic [CntW-1:0] k_q, k_d;
  logic [11:0]     prev_q, prev_d;
  logic            ovf_q, ovf_d;

  logic [11:0] x, dabs;
  logic [23:0] xsq, dsq_term;
  assign x        = in_i.interval_ms;
  assign dabs     = (x >= prev_q) ? x - prev_q : prev_q - x;
  assign xsq      = x * x;
  assign dsq_term = dabs * dabs;

  always_comb begin
    cnt_d = cnt_q; sum_d = sum_q; sq_d = sq_q; dsq_d = dsq_q;
    k_d = k_q; prev_d = prev_q; ovf_d = ovf_q;
    if (cmd_i.accum) begin
      if (cnt_q < CntW'(MaxSamples)) begin
        sum_d  = sum_q + SumW'(x);
        sq_d   = sq_q + SqW'(xsq);
        if (cnt_q != '0) begin
          dsq_d = dsq_q + SqW'(dsq_term);
          if (dabs >= nn_diff_limit_i) k_d = k_q + CntW'(1);
        end
        prev_d = x;
        cnt_d  = cnt_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.emit) begin
      cnt_d = '0; sum_d = '0; sq_d = '0; dsq_d = '0;
      k_d = '0; prev_d = '0; ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sum_q <= '0; sq_q <= '0; dsq_q <= '0;
      k_q <= '0; prev_q <= '0; ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; sum_q <= sum_d; sq_q <= sq_d; dsq_q <= dsq_d;
      k_q <= k_d; prev_q <= prev_d; ovf_q <= ovf_d;
    end
  end

  assign sts_o.need_fin = (cnt_q >= CntW'(2));

  // finishing operands, registered when fin_start is issued
  logic [SqW+CntW-1:0] nq_q;
  logic [2*SumW-1:0]   ss_q;
  logic [DenW-1:0]     nm_q;
  logic [CntW-1:0]     m_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_start) begin
      nq_q <= (SqW+CntW)'(cnt_q) * (SqW+CntW)'(sq_q);
      ss_q <= (2*SumW)'(sum_q) * (2*SumW)'(sum_q);
      nm_q <= DenW'(cnt_q) * DenW'(cnt_q - CntW'(1));
      m_q  <= cnt_q - CntW'(1);
    end
  end

  // restoring divider, one quotient bit per cycle
  localparam int unsigned DivCntW = $clog2(NumW + 1);
  logic [NumW-1:0]    quo_q, div_num;
  logic [DenW:0]      rem_q;
  logic [DenW-1:0]    den_q, div_den;
  logic [DivCntW-1:0] dcnt_q;
  logic               dbusy_q;
  logic [DenW:0]      rem_sh;

  always_comb begin
    case (cmd_i.div_sel)
      DivSelVar: begin
        div_num = NumW'(NumW'(nq_q) - NumW'(ss_q)) << 8;
        div_den = nm_q;
      end
      DivSelDiff: begin
        div_num = NumW'(dsq_q) << 8;
        div_den = DenW'(m_q);
      end
      default: begin
        div_num = NumW'(k_q) * NumW'(1600);
        div_den = DenW'(m_q);
      end
    endcase
  end

  assign rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= DivCntW'(NumW);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - DivCntW'(1);
      if (dcnt_q == DivCntW'(1)) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= div_num;
      rem_q <= '0;
      den_q <= div_den;
    end else if (dbusy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = dbusy_q && (dcnt_q == DivCntW'(1));

  // quotient holding registers
  logic [NumW-1:0] vq_q, dq_q;
  logic [10:0]     pq_q;
  logic            div_done_q;
  logic [1:0]      dsel_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) dsel_q <= cmd_i.div_sel;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_done_q <= 1'b0;
    else         div_done_q <= sts_o.div_done;
  end
  always_ff @(posedge clk_i) begin
    if (div_done_q) begin
      case (dsel_q)
        DivSelVar:  vq_q <= quo_q;
        DivSelDiff: dq_q <= quo_q;
        default:    pq_q <= quo_q[10:0];
      endcase
    end
  end

  // digit-by-digit square root, two radicand bits per cycle
  localparam int unsigned RtW  = NumW / 2 + 1;
  localparam int unsigned RadW = 2 * RtW;
  localparam int unsigned SqCntW = $clog2(RtW + 1);
  logic [RadW-1:0]   rad_q;
  logic [RtW+1:0]    srem_q, srem_sh, trial;
  logic [RtW-1:0]    root_q;
  logic [SqCntW-1:0] scnt_q;
  logic              sbusy_q;

  assign srem_sh = {srem_q[RtW-1:0], rad_q[RadW-1 -: 2]};
  assign trial   = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      scnt_q  <= '0;
    end else if (cmd_i.sqrt_start) begin
      sbusy_q <= 1'b1;
      scnt_q  <= SqCntW'(RtW);
    end else if (sbusy_q) begin
      scnt_q <= scnt_q - SqCntW'(1);
      if (scnt_q == SqCntW'(1)) sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= cmd_i.sqrt_sel ? RadW'(dq_q) : RadW'(vq_q);
      srem_q <= '0;
      root_q <= '0;
    end else if (sbusy_q) begin
      rad_q <= rad_q << 2;
      if (srem_sh >= trial) begin
        srem_q <= srem_sh - trial;
        root_q <= {root_q[RtW-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh;
        root_q <= {root_q[RtW-2:0], 1'b0};
      end
    end
  end
  assign sts_o.sqrt_done = sbusy_q && (scnt_q == SqCntW'(1));

  logic [RtW-1:0] sdnn_rt_q, rmssd_rt_q;
  logic           sqrt_done_q, ssel_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) ssel_q <= cmd_i.sqrt_sel;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sqrt_done_q <= 1'b0;
    else         sqrt_done_q <= sts_o.sqrt_done;
  end
  always_ff @(posedge clk_i) begin
    if (sqrt_done_q) begin
      if (ssel_q) rmssd_rt_q <= root_q;
      else        sdnn_rt_q  <= root_q;
    end
  end

  // result assembly
  logic       p0, p1, p2;
  logic [1:0] pts;
  assign p0  = RtW'(sdnn_rt_q)  < RtW'({sdnn_limit_i, 4'd0});
  assign p1  = RtW'(rmssd_rt_q) < RtW'({rmssd_limit_i, 4'd0});
  assign p2  = pq_q < {pnn50_limit_i, 4'd0};
  assign pts = 2'(p0) + 2'(p1) + 2'(p2);

  always_comb begin
    res_o = '0;
    if (!sts_o.need_fin) begin
      res_o.window_status = StatusShort;
    end else begin
      res_o.sdnn_q4  = (sdnn_rt_q > RtW'(16'hFFFF)) ? 16'hFFFF : sdnn_rt_q[15:0];
      res_o.rmssd_q4 = (rmssd_rt_q > RtW'(16'hFFFF)) ? 16'hFFFF : rmssd_rt_q[15:0];
      res_o.pnn50_q4 = pq_q;
      res_o.stress_points = pts;
      res_o.stress_colour = (pts >= 2'd2) ? 2'd2 : pts;
      res_o.window_status = ovf_q ? StatusOver : StatusOk;
    end
  end
endmodule

[rtl/hrv_ctrl.sv]
// Controller: sequences accumulation, divisions, square roots and output
module hrv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hrv_pkg::hrv_cmd_t cmd_o,
  input  hrv_pkg::hrv_sts_t sts_i,
  output logic              load_o
);
  import hrv_pkg::*;
  `include "hrv_stress_classifier_assert.svh"

  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StFin    = 11'b00000000010,
    StDivV   = 11'b00000000100,
    StDivD   = 11'b00000001000,
    StDivP   = 11'b00000010000,
    StSqS    = 11'b00000100000,
    StSqR    = 11'b00001000000,
    StEmit   = 11'b00010000000,
    StWaitD  = 11'b00100000000,
    StWaitS  = 11'b01000000000,
    StSettle = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   started_q, started_d;
  logic   out_valid_q, out_valid_d;
  // selector of the last division issued in this window
  logic [1:0] div_seq_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    started_d   = 1'b0;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    load_o      = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accum = 1'b1;
          if (last_i) state_d = StFin;
        end
      end
      StFin: begin
        // sts_i reflects the window including the last sample
        if (!out_valid_q) begin
          if (sts_i.need_fin) begin
            cmd_o.fin_start = 1'b1;
            state_d = StDivV;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StDivV: begin
        cmd_o.div_start = 1'b1; cmd_o.div_sel = DivSelVar;
        state_d = StWaitD; started_d = 1'b0;
      end
      StDivD: begin
        cmd_o.div_start = 1'b1; cmd_o.div_sel = DivSelDiff;
        state_d = StWaitD; started_d = 1'b1;
      end
      StDivP: begin
        cmd_o.div_start = 1'b1; cmd_o.div_sel = DivSelPnn;
        state_d = StWaitD;
      end
      StWaitD: begin
        started_d = started_q;
        if (sts_i.div_done) begin
          if (started_q) state_d = StDivP;
          else state_d = StDivD;
        end
        if (div_seq_q == DivSelPnn && sts_i.div_done) state_d = StSqS;
      end
      StSqS: begin
        cmd_o.sqrt_start = 1'b1; cmd_o.sqrt_sel = 1'b0;
        state_d = StWaitS; started_d = 1'b0;
      end
      StSqR: begin
        cmd_o.sqrt_start = 1'b1; cmd_o.sqrt_sel = 1'b1;
        state_d = StWaitS; started_d = 1'b1;
      end
      StWaitS: begin
        started_d = started_q;
        if (sts_i.sqrt_done) state_d = started_q ? StSettle : StSqR;
      end
      StSettle: begin
        // this idle state after the last done lets the root register settle
        state_d = StEmit;
      end
      StEmit: begin
        load_o      = 1'b1;
        cmd_o.emit  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_seq_q <= DivSelVar;
    else if (state_q == StFin) div_seq_q <= DivSelVar;
    else if (cmd_o.div_start) div_seq_q <= cmd_o.div_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  `HRV_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_q))
  `HRV_ASSERT_NEXT(a_emit_valid, cmd_o.emit, out_valid_o)
  `HRV_ASSERT_IMP(a_fin_idle_out, cmd_o.fin_start, !out_valid_o)
endmodule

[verif/tb_hrv_stress_classifier.sv]
// Self-checking testbench for the HRV stress classifier
module tb_hrv_stress_classifier;
  import hrv_pkg::*;

  localparam int unsigned WIN_MAX = 128;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;

  // window statistics predictor and queue of expected window summaries
  class hrv_scoreboard;
    logic [11:0] sdnn_lim, rmssd_lim, diff_lim;
    logic [6:0]  pnn_lim;
    int unsigned n_kept;
    longint unsigned sum_x, sum_sq, sum_dsq;
    int unsigned big_diffs;
    logic [11:0] prev_x;
    bit dropped;
    hrv_out_t summaries[$];
    int unsigned errors;

    function void clear_window();
      n_kept = 0; sum_x = 0; sum_sq = 0; sum_dsq = 0;
      big_diffs = 0; prev_x = '0; dropped = 0;
    endfunction

    function void reset_limits();
      sdnn_lim = 12'd50; rmssd_lim = 12'd42; pnn_lim = 7'd3; diff_lim = 12'd50;
      clear_window();
    endfunction

    function void set_limit(logic [1:0] idx, logic [11:0] val);
      case (idx)
        CfgSdnn:  sdnn_lim = val;
        CfgRmssd: rmssd_lim = val;
        CfgPnn:   pnn_lim = val[6:0];
        CfgDiff:  diff_lim = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_sample(hrv_in_t s);
      longint unsigned d, n, m, sd, rm, pn;
      hrv_out_t e;
      if (n_kept < WIN_MAX) begin
        sum_x += s.interval_ms;
        sum_sq += longint'(s.interval_ms) * s.interval_ms;
        if (n_kept > 0) begin
          d = (s.interval_ms >= prev_x) ? s.interval_ms - prev_x : prev_x - s.interval_ms;
          sum_dsq += d * d;
          if (d >= diff_lim) big_diffs++;
        end
        prev_x = s.interval_ms;
        n_kept++;
      end else begin
        dropped = 1;
      end
      if (!s.last_sample) return;
      e = '0;
      if (n_kept < 2) begin
        e.window_status = StatusShort;
      end else begin
        n = n_kept;
        m = n - 1;
        sd = int_root((256 * (n * sum_sq - sum_x * sum_x)) / (n * m));
        rm = int_root((256 * sum_dsq) / m);
        pn = (1600 * longint'(big_diffs)) / m;
        e.stress_points = (sd < 16 * longint'(sdnn_lim)) + (rm < 16 * longint'(rmssd_lim))
                        + (pn < 16 * longint'(pnn_lim));
        e.stress_colour = (e.stress_points >= 2) ? 2'd2 : e.stress_points;
        e.window_status = dropped ? StatusOver : StatusOk;
        e.sdnn_q4 = (sd > 65535) ? 16'hFFFF : sd[15:0];
        e.rmssd_q4 = (rm > 65535) ? 16'hFFFF : rm[15:0];
        e.pnn50_q4 = pn[10:0];
      end
      summaries.push_back(e);
      clear_window();
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check_result(hrv_out_t r);
      hrv_out_t e;
      if (summaries.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = summaries.pop_front();
      if (r.sdnn_q4 !== e.sdnn_q4) report("sdnn_q4", r.sdnn_q4, e.sdnn_q4);
      if (r.rmssd_q4 !== e.rmssd_q4) report("rmssd_q4", r.rmssd_q4, e.rmssd_q4);
      if (r.pnn50_q4 !== e.pnn50_q4) report("pnn50_q4", r.pnn50_q4, e.pnn50_q4);
      if (r.stress_points !== e.stress_points)
        report("stress_points", r.stress_points, e.stress_points);
      if (r.stress_colour !== e.stress_colour)
        report("stress_colour", r.stress_colour, e.stress_colour);
      if (r.window_status !== e.window_status)
        report("window_status", r.window_status, e.window_status);
    endtask
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, out_ready_i = 1'b0, cfg_we_i = 1'b0;
  logic in_ready_o, out_valid_o;
  hrv_in_t in_data_i = '0;
  hrv_out_t out_data_o;
  logic [1:0] cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;

  hrv_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  bit hold_off = 0;
  bit sink_quiet = 0;

  hrv_stress_classifier #(.MAX_SAMPLES(WIN_MAX)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays high across back-to-back transfers; a gap drops it first
  task automatic send_sample(logic [11:0] x, logic last);
    int unsigned g;
    g = gap_len() * int'(!sink_quiet);
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{interval_ms: x, last_sample: last};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(in_data_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic write_limit(logic [1:0] idx, logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(idx, val);
  endtask

  // let every pending summary arrive, then cover the finishing latency
  task automatic wait_idle();
    stop_sending();
    while (sb.summaries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_window(int unsigned len, int unsigned mode);
    logic [11:0] x, base;
    base = 12'($urandom_range(300, 1500));
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: x = 12'($urandom_range(0, 4095));
        1: x = 12'(base + $urandom_range(0, 120) - 60);
        2: x = (i % 2) ? 12'hFFF : 12'h000;
        default: x = base;
      endcase
      send_sample(x, i == len - 1);
    end
  endtask

  // receiver: random stalls, sampling on the rising edge
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(out_data_o);
      idle_cycles <= 0;
    end else if (in_valid_i && in_ready_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    out_ready_i <= !hold_off && ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    sb.reset_limits();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: short windows, extremes, overflow, flat and alternating data
    send_sample(12'd800, 1'b1);
    send_window(2, 2);
    send_window(3, 3);
    send_window(4, 1);
    send_window(5, 0);
    send_window(WIN_MAX + 3, 2);
    wait_idle();
    write_limit(CfgSdnn, 12'hFFF);
    write_limit(CfgRmssd, 12'hFFF);
    write_limit(CfgPnn, 12'd100);
    write_limit(CfgDiff, 12'd0);
    send_window(2, 2);
    send_window(3, 1);
    wait_idle();
    write_limit(CfgSdnn, 12'd0);
    write_limit(CfgRmssd, 12'd0);
    write_limit(CfgPnn, 12'd0);
    write_limit(CfgDiff, 12'hFFF);
    send_window(2, 2);
    send_window(3, 0);

    // receiver held off while the sender keeps offering
    wait_idle();
    hold_off = 1;
    fork
      begin
        repeat (2000) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        send_window(3, 1);
        send_window(3, 1);
        send_window(3, 1);
        stop_sending();
      end
    join

    for (int unsigned ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_limit(CfgSdnn, 12'($urandom_range(0, 200)));
      write_limit(CfgRmssd, 12'($urandom_range(0, 200)));
      write_limit(CfgPnn, 12'($urandom_range(0, 100)));
      write_limit(CfgDiff, 12'($urandom_range(0, 150)));
      sink_quiet = (ph == 2);
      for (int unsigned w = 0; w < 10; w++) begin
        int unsigned len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, WIN_MAX + 4)
                                           : $urandom_range(1, 12);
        send_window(len, $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3));
      end
    end
    sink_quiet = 0;

    wait_idle();
    if (sb.errors == 0 && sb.summaries.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[hrv_stress_classifier.f]
+incdir+rtl
rtl/hrv_pkg.sv
rtl/hrv_datapath.sv
rtl/hrv_ctrl.sv
rtl/hrv_stress_classifier.sv
verif/tb_hrv_stress_classifier.sv
